// ===== hdl/tpt_pkg.sv =====
// Shared types and constants of the tracker peer table.
package tpt_pkg;

  localparam logic [1:0] KIND_ANNOUNCE = 2'd0;
  localparam logic [1:0] KIND_PURGE    = 2'd1;
  localparam logic [1:0] KIND_SCRAPE   = 2'd2;
  localparam logic [1:0] KIND_UNUSED   = 2'd3;

  localparam logic [1:0] EV_NONE      = 2'd0;
  localparam logic [1:0] EV_COMPLETED = 2'd1;
  localparam logic [1:0] EV_STARTED   = 2'd2;
  localparam logic [1:0] EV_STOPPED   = 2'd3;

  localparam int RUN_CAP = 200;

  // One classified request as it travels from the front part to the back part.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_seconds;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic [1:0]  event_req;
    logic        seed;
    logic [31:0] wanted;
    logic [31:0] random_value;
  } req_t;

  localparam int REQ_W = $bits(req_t);

endpackage

// ===== hdl/tracker_peer_table_core.sv =====
// An announce reads each stored slot in turn for the address lookup, runs the divider
// for each remainder that draws a run start or an eviction slot, then reads and sends
// each returned peer. A purge tick reads each checked slot and moves the tail entry
// into each removed one; a scrape answers from the counters. Requests are worked one
// at a time by the back sequencer behind a 2-entry queue. Synchronous reset empties
// the table and counters; no clearing pass.
module tracker_peer_table_core #(
  parameter int MAX_PEERS   = 4096,
  parameter int MAX_RETURN  = 64,
  parameter int PURGE_BATCH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: now_seconds, peer_ip, peer_port, event_req, bytes_left, wanted, random_value
  input  logic [183:0] s_tdata,
  // tuser: kind
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata: seed_count, downloader_count, completed_count, peer_ip_out, peer_port_out
  output logic [111:0] m_tdata,
  // tuser: peer_valid
  output logic         m_tuser,
  output logic         m_tlast
);
  import tpt_pkg::*;

  logic [15:0] interval;
  logic        q_valid, q_ready;
  req_t        q_data;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) interval <= 16'd1800;
    else if (cfg_valid) interval <= cfg_data;
  end

  tpt_front u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .kind(s_tuser), .now_seconds(s_tdata[31:0]), .peer_ip(s_tdata[63:32]),
    .peer_port(s_tdata[79:64]), .event_req(s_tdata[81:80]),
    .bytes_left(s_tdata[113:82]), .wanted(s_tdata[145:114]),
    .random_value(s_tdata[177:146]),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  tpt_back #(.MAX_PEERS(MAX_PEERS), .MAX_RETURN(MAX_RETURN),
             .PURGE_BATCH(PURGE_BATCH)) u_back (
    .clk(clk), .rst(rst), .interval(interval),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );
endmodule

// ===== hdl/tpt_ram.sv =====
// Generic single-port RAM with registered read.
module tpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== hdl/tpt_front.sv =====
// Front part: accepts requests, drops unused kinds, and queues them.
module tpt_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [1:0]    kind,
  input  logic [31:0]   now_seconds,
  input  logic [31:0]   peer_ip,
  input  logic [15:0]   peer_port,
  input  logic [1:0]    event_req,
  input  logic [31:0]   bytes_left,
  input  logic [31:0]   wanted,
  input  logic [31:0]   random_value,
  output logic          q_valid,
  input  logic          q_ready,
  output tpt_pkg::req_t q_data
);
  import tpt_pkg::*;

  localparam int QD = 2;
  req_t       q [QD];
  logic [0:0] wp, rp;
  logic [1:0] cnt;
  logic       push, pop;
  req_t       r;

  always_comb begin
    r.kind         = kind;
    r.now_seconds  = now_seconds;
    r.peer_ip      = peer_ip;
    r.peer_port    = peer_port;
    r.event_req    = event_req;
    r.seed         = (bytes_left == 32'd0);
    r.wanted       = wanted;
    r.random_value = random_value;
  end

  assign s_tready = (cnt != 2'd2);
  // An unused kind is taken and thrown away here.
  assign push     = s_tvalid && s_tready && (kind != KIND_UNUSED);
  assign q_valid  = (cnt != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= r;
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== hdl/tpt_div.sv =====
// Restoring divider: remainder of a 32-bit value by a count, one bit a cycle.
module tpt_div #(
  parameter int CW = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [CW-1:0] divisor,
  output logic          done,
  output logic [CW-1:0] rem
);
  logic [31:0] q;
  logic [CW:0] r;
  logic [5:0]  cnt;
  logic        busy;
  logic [CW:0] sh;

  assign sh   = {r[CW-1:0], q[31]};
  assign rem  = r[CW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1; q <= dividend; r <= '0; cnt <= 6'd0;
      end else if (busy) begin
        q <= {q[30:0], 1'b0};
        if (sh >= {1'b0, divisor}) r <= sh - {1'b0, divisor};
        else r <= sh;
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0; done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hdl/tpt_back.sv =====
// Back part: table sequencer for purge, lookup, update and peer run output.
module tpt_back #(
  parameter int MAX_PEERS   = 4096,
  parameter int MAX_RETURN  = 64,
  parameter int PURGE_BATCH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [15:0]           interval,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  tpt_pkg::req_t         q_data,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [111:0]          m_tdata,
  output logic                  m_tlast,
  output logic                  m_tuser
);
  import tpt_pkg::*;

  localparam int AW = $clog2(MAX_PEERS);
  localparam int CW = $clog2(MAX_PEERS + 1);
  localparam int EW = 82;
  localparam int NCAP = (MAX_RETURN < RUN_CAP) ? MAX_RETURN : RUN_CAP;
  localparam int BW = $clog2(PURGE_BATCH + 1);

  localparam logic [1:0] RET_PURGE = 2'd0;
  localparam logic [1:0] RET_EVICT = 2'd1;
  localparam logic [1:0] RET_STOP  = 2'd2;

  typedef enum logic [15:0] {
    S_IDLE   = 16'b0000000000000001,
    S_PRD    = 16'b0000000000000010,
    S_PCHK   = 16'b0000000000000100,
    S_TRD    = 16'b0000000000001000,
    S_TWR    = 16'b0000000000010000,
    S_LRD    = 16'b0000000000100000,
    S_LCHK   = 16'b0000000001000000,
    S_EVDIV  = 16'b0000000010000000,
    S_UPD    = 16'b0000000100000000,
    S_UWR    = 16'b0000001000000000,
    S_RDIV   = 16'b0000010000000000,
    S_ORD    = 16'b0000100000000000,
    S_OWAIT  = 16'b0001000000000000,
    S_OUT    = 16'b0010000000000000,
    S_SINGLE = 16'b0100000000000000,
    S_DONE   = 16'b1000000000000000
  } state_t;

  state_t       st;
  req_t         rq;
  logic [CW-1:0] count, seeds, dls;
  logic [31:0]  comps;
  logic [AW-1:0] cursor;
  logic [CW-1:0] sc0, dc0;
  logic [BW-1:0] batch;
  logic [CW-1:0] idx;
  logic [AW-1:0] hole;
  logic [1:0]   tail_ret;
  logic         found;
  logic [CW-1:0] fslot;
  logic [CW-1:0] oidx, oend, n;
  logic [6:0]   fill;

  // entry: ip 32, port 16, last_seen 32, complete, downloading
  logic          we;
  logic [AW-1:0] addr;
  logic [EW-1:0] wdata, rdata, held;

  tpt_ram #(.WIDTH(EW), .DEPTH(MAX_PEERS)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  logic          dstart, ddone;
  logic [CW-1:0] drem;
  tpt_div #(.CW(CW)) u_div (
    .clk(clk), .rst(rst), .start(dstart), .dividend(rq.random_value),
    .divisor(count), .done(ddone), .rem(drem)
  );

  logic [31:0] limit, age;
  assign limit = {16'd0, interval} + {17'd0, interval[15:1]};
  assign age   = rq.now_seconds - rdata[33:2];

  logic [31:0]   nwide;
  logic [CW-1:0] ncalc;
  always_comb begin
    nwide = 32'(NCAP);
    if (32'(count) < nwide) nwide = 32'(count);
    if (rq.wanted < nwide) nwide = rq.wanted;
  end
  assign ncalc = nwide[CW-1:0];

  // A purge tick checks at most as many slots as the table holds at its start.
  logic [BW-1:0] pb_first;
  assign pb_first = (32'(count) < 32'(PURGE_BATCH)) ? BW'(count) : BW'(PURGE_BATCH);

  assign q_ready = (st == S_IDLE);

  logic [CW-1:0] tailv;
  assign tailv = count - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; count <= '0; seeds <= '0; dls <= '0; comps <= '0;
      cursor <= '0; m_tvalid <= 1'b0; we <= 1'b0; dstart <= 1'b0;
    end else begin
      we <= 1'b0;
      dstart <= 1'b0;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (st)
        S_IDLE: if (q_valid) begin
          rq <= q_data; sc0 <= seeds; dc0 <= dls;
          if (q_data.kind == KIND_SCRAPE) st <= S_SINGLE;
          else begin
            batch <= (q_data.kind == KIND_PURGE) ? pb_first : BW'(1);
            st <= S_PRD;
          end
        end
        S_PRD: begin
          if (batch == '0 || count == '0) begin
            if (rq.kind == KIND_PURGE) st <= S_IDLE;
            else begin idx <= '0; found <= 1'b0; st <= S_LRD; end
          end else begin
            if ({1'b0, cursor} >= (AW+1)'(count)) cursor <= '0;
            addr <= ({1'b0, cursor} >= (AW+1)'(count)) ? '0 : cursor;
            fill <= 7'd0;
            st <= S_PCHK;
          end
        end
        S_PCHK: begin
          fill <= fill + 7'd1;
          // Wait for the registered read to land.
          if (fill == 7'd1) begin
            if (age > limit) begin
              hole <= addr; tail_ret <= RET_PURGE; st <= S_TRD;
              held <= rdata;
            end else begin
              cursor <= addr + 1'b1; batch <= batch - 1'b1; st <= S_PRD;
            end
          end
        end
        S_TRD: begin
          if (held[0]) begin if (dls != '0) dls <= dls - 1'b1; end
          else begin if (seeds != '0) seeds <= seeds - 1'b1; end
          addr <= tailv[AW-1:0]; st <= S_TWR; fill <= 7'd0;
        end
        S_TWR: begin
          fill <= fill + 7'd1;
          if (fill == 7'd1) begin
            addr <= hole; wdata <= rdata; we <= 1'b1; count <= tailv;
            case (tail_ret)
              RET_PURGE: begin batch <= batch - 1'b1; st <= S_PRD; end
              RET_EVICT: st <= S_UPD;
              default: st <= S_SINGLE;
            endcase
          end
        end
        S_LRD: begin
          if (idx >= count) begin
            if (rq.event_req == EV_STOPPED) st <= S_SINGLE;
            else if (count >= CW'(MAX_PEERS)) begin dstart <= 1'b1; st <= S_EVDIV; end
            else st <= S_UPD;
          end else begin addr <= idx[AW-1:0]; fill <= 7'd0; st <= S_LCHK; end
        end
        S_LCHK: begin
          fill <= fill + 7'd1;
          if (fill == 7'd1) begin
            if (rdata[81:50] == rq.peer_ip) begin
              found <= 1'b1; fslot <= idx; held <= rdata;
              if (rq.event_req == EV_STOPPED) begin
                hole <= idx[AW-1:0]; tail_ret <= RET_STOP; st <= S_TRD;
              end else st <= S_UPD;
            end else begin idx <= idx + 1'b1; st <= S_LRD; end
          end
        end
        S_EVDIV: if (ddone) begin
          // Fetch the victim, then remove it through the tail move.
          hole <= drem[AW-1:0]; addr <= drem[AW-1:0]; fill <= 7'd0;
          tail_ret <= RET_EVICT;
          st <= S_UWR;
        end
        S_UWR: begin
          fill <= fill + 7'd1;
          if (fill == 7'd1) begin held <= rdata; st <= S_TRD; end
        end
        S_UPD: begin
          if (!found) begin
            addr <= count[AW-1:0]; we <= 1'b1;
            wdata <= {rq.peer_ip, rq.peer_port, rq.now_seconds,
                      rq.event_req == EV_COMPLETED, !rq.seed};
            if (rq.event_req == EV_COMPLETED) comps <= comps + 32'd1;
            if (rq.seed) seeds <= seeds + 1'b1; else dls <= dls + 1'b1;
            count <= count + 1'b1;
          end else begin
            addr <= fslot[AW-1:0]; we <= 1'b1;
            wdata <= {held[81:50], rq.peer_port, rq.now_seconds,
                      held[1] | (rq.event_req == EV_COMPLETED), !rq.seed};
            if (rq.event_req == EV_COMPLETED && !held[1]) comps <= comps + 32'd1;
            if (rq.seed && held[0]) begin
              if (dls != '0) dls <= dls - 1'b1;
              seeds <= seeds + 1'b1;
            end else if (!rq.seed && !held[0]) begin
              if (seeds != '0) seeds <= seeds - 1'b1;
              dls <= dls + 1'b1;
            end
          end
          st <= S_RDIV;
          fill <= 7'd0;
        end
        S_RDIV: begin
          if (fill == 7'd0) begin
            fill <= 7'd1;
            n <= ncalc;
            if (ncalc == '0) st <= S_SINGLE;
            else if (count <= ncalc) begin
              oidx <= '0; oend <= count; st <= S_ORD;
            end else dstart <= 1'b1;
          end else if (ddone) begin
            oidx <= drem;
            oend <= ((count - drem) > n) ? drem + n : count;
            st <= S_ORD;
          end
        end
        S_ORD: if (!m_tvalid || m_tready) begin
          addr <= oidx[AW-1:0]; fill <= 7'd0; st <= S_OWAIT;
        end
        S_OWAIT: begin
          fill <= fill + 7'd1;
          if (fill == 7'd1) st <= S_OUT;
        end
        S_OUT: if (!m_tvalid || m_tready) begin
          m_tvalid <= 1'b1;
          m_tdata  <= {6'd0, rdata[49:34], rdata[81:50], 32'd0, 13'(dc0), 13'(sc0)};
          m_tuser  <= 1'b1;
          m_tlast  <= (oidx + 1'b1 == oend);
          oidx <= oidx + 1'b1;
          st <= (oidx + 1'b1 == oend) ? S_DONE : S_ORD;
        end
        S_SINGLE: if (!m_tvalid || m_tready) begin
          m_tvalid <= 1'b1;
          m_tdata  <= {6'd0, 48'd0,
                       (rq.kind == KIND_SCRAPE) ? comps : 32'd0,
                       13'((rq.kind == KIND_SCRAPE) ? dls : dc0),
                       13'((rq.kind == KIND_SCRAPE) ? seeds : sc0)};
          m_tuser  <= 1'b0;
          m_tlast  <= 1'b1;
          st <= S_DONE;
        end
        S_DONE: st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== tb/tracker_peer_table_core_test.sv =====
// Self-checking testbench of the tracker peer table core with its own table predictor.
`timescale 1ns / 100ps

module tracker_peer_table_core_test;
  import tpt_pkg::*;

  localparam int TABLE_SIZE = 4096;
  localparam int RETURN_MAX = 64;
  localparam int PURGE_MAX  = 64;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    logic [12:0] seeds;
    logic [12:0] downloaders;
    logic [31:0] completed;
    logic        has_peer;
    logic [31:0] ip;
    logic [15:0] port;
    logic        last;
  } reply_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [15:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [183:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [111:0] m_tdata;
  logic         m_tuser;
  logic         m_tlast;

  tracker_peer_table_core #(
    .MAX_PEERS(TABLE_SIZE),
    .MAX_RETURN(RETURN_MAX),
    .PURGE_BATCH(PURGE_MAX)
  ) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  // Shadow copy of the peer table.
  logic [31:0] peer_ip_tab [TABLE_SIZE];
  logic [15:0] peer_port_tab [TABLE_SIZE];
  logic [31:0] peer_seen_tab [TABLE_SIZE];
  logic        peer_done_tab [TABLE_SIZE];
  logic        peer_dl_tab [TABLE_SIZE];
  int unsigned peer_total, seed_total, dl_total, cursor;
  logic [31:0] completed_total;
  logic [15:0] interval;

  reply_t pending_replies[$];
  int errors = 0;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int hold_off = 0;
  int unsigned cycles = 0;
  logic [31:0] clock_now = 32'd1000;
  logic [31:0] ip_pool [24];

  function automatic void drop_peer(int unsigned s);
    int unsigned tail;
    if (peer_total == 0 || s >= peer_total) return;
    if (peer_dl_tab[s]) begin
      if (dl_total > 0) dl_total--;
    end else if (seed_total > 0) seed_total--;
    tail = peer_total - 1;
    peer_ip_tab[s] = peer_ip_tab[tail];
    peer_port_tab[s] = peer_port_tab[tail];
    peer_seen_tab[s] = peer_seen_tab[tail];
    peer_done_tab[s] = peer_done_tab[tail];
    peer_dl_tab[s] = peer_dl_tab[tail];
    peer_total = tail;
  endfunction

  function automatic void age_check(logic [31:0] now);
    logic [31:0] limit;
    logic [31:0] age;
    limit = {16'd0, interval} + {17'd0, interval[15:1]};
    if (peer_total == 0) return;
    if (cursor >= peer_total) cursor = 0;
    age = now - peer_seen_tab[cursor];
    if (age > limit) drop_peer(cursor);
    else cursor++;
  endfunction

  function automatic void push_reply(int unsigned sc, int unsigned dc, logic [31:0] cc,
                                     logic v, logic [31:0] ip, logic [15:0] port, logic l);
    reply_t r;
    r.seeds = sc[12:0];
    r.downloaders = dc[12:0];
    r.completed = cc;
    r.has_peer = v;
    r.ip = ip;
    r.port = port;
    r.last = l;
    pending_replies.insert(pending_replies.size(), r);
  endfunction

  function automatic void table_predict(logic [1:0] kind, logic [31:0] now, logic [31:0] ip,
                                        logic [15:0] port, logic [1:0] ev, logic [31:0] left,
                                        logic [31:0] wanted, logic [31:0] rnd);
    int unsigned sc0, dc0, s, n, start, len, num;
    bit found;
    found = 0;
    if (kind == KIND_PURGE) begin
      num = peer_total < PURGE_MAX ? peer_total : PURGE_MAX;
      for (int k = 0; k < num; k++) age_check(now);
      return;
    end
    if (kind == KIND_SCRAPE) begin
      push_reply(seed_total, dl_total, completed_total, 1'b0, 32'd0, 16'd0, 1'b1);
      return;
    end
    if (kind != KIND_ANNOUNCE) return;
    sc0 = seed_total;
    dc0 = dl_total;
    age_check(now);
    for (s = 0; s < peer_total; s++)
      if (peer_ip_tab[s] == ip) begin
        found = 1;
        break;
      end
    if (ev == EV_STOPPED) begin
      if (found) drop_peer(s);
      push_reply(sc0, dc0, 32'd0, 1'b0, 32'd0, 16'd0, 1'b1);
      return;
    end
    if (!found) begin
      if (peer_total >= TABLE_SIZE) drop_peer(rnd % peer_total);
      s = peer_total;
      peer_ip_tab[s] = ip;
      peer_port_tab[s] = port;
      peer_seen_tab[s] = now;
      peer_done_tab[s] = (ev == EV_COMPLETED);
      if (ev == EV_COMPLETED) completed_total++;
      peer_dl_tab[s] = (left != 0);
      if (left != 0) dl_total++;
      else seed_total++;
      peer_total = s + 1;
    end else begin
      peer_seen_tab[s] = now;
      if (ev == EV_COMPLETED && !peer_done_tab[s]) begin
        peer_done_tab[s] = 1;
        completed_total++;
      end
      if (left == 0 && peer_dl_tab[s]) begin
        peer_dl_tab[s] = 0;
        if (dl_total > 0) dl_total--;
        seed_total++;
      end else if (left != 0 && !peer_dl_tab[s]) begin
        peer_dl_tab[s] = 1;
        if (seed_total > 0) seed_total--;
        dl_total++;
      end
      peer_port_tab[s] = port;
    end
    n = RUN_CAP < RETURN_MAX ? RUN_CAP : RETURN_MAX;
    if (peer_total < n) n = peer_total;
    if (wanted < n) n = wanted;
    if (n == 0) begin
      push_reply(sc0, dc0, 32'd0, 1'b0, 32'd0, 16'd0, 1'b1);
      return;
    end
    if (peer_total <= n) begin
      start = 0;
      len = peer_total;
    end else begin
      start = rnd % peer_total;
      len = peer_total - start;
      if (len > n) len = n;
    end
    for (int k = 0; k < len; k++)
      push_reply(sc0, dc0, 32'd0, 1'b1, peer_ip_tab[start + k], peer_port_tab[start + k],
                 k + 1 == len);
  endfunction

  task automatic send_request(logic [1:0] kind, logic [31:0] now, logic [31:0] ip,
                              logic [15:0] port, logic [1:0] ev, logic [31:0] left,
                              logic [31:0] wanted, logic [31:0] rnd);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {6'd0, rnd, wanted, left, ev, port, ip, now};
    do @(posedge clk); while (!s_tready);
    table_predict(kind, now, ip, port, ev, left, wanted, rnd);
  endtask

  // Waits until every reply is in, then for the slowest purge pass to finish.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  task automatic write_interval(logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    interval = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_request();
    logic [1:0] kind;
    logic [31:0] ip, left, wanted;
    int pick;
    pick = $urandom_range(99);
    kind = pick < 75 ? KIND_ANNOUNCE : pick < 87 ? KIND_PURGE :
           pick < 97 ? KIND_SCRAPE : KIND_UNUSED;
    ip = $urandom_range(9) == 0 ? $urandom : ip_pool[$urandom_range(23)];
    left = $urandom_range(1) ? 32'd0 : $urandom;
    wanted = $urandom_range(7) == 0 ? $urandom : $urandom_range(80);
    if ($urandom_range(15) == 0) clock_now += 32'd5000;
    else clock_now += $urandom_range(300);
    send_request(kind, clock_now, ip, 16'($urandom), 2'($urandom_range(3)), left, wanted,
                 $urandom);
  endtask

  task automatic test_directed();
    clock_now = 32'hFFFF_FF00;
    send_request(KIND_SCRAPE, clock_now, 32'd0, 16'd0, EV_NONE, 32'd0, 32'd0, 32'd0);
    send_request(KIND_ANNOUNCE, clock_now, 32'd0, 16'd0, EV_NONE, 32'd0, 32'd0, 32'd0);
    send_request(KIND_ANNOUNCE, clock_now, 32'hFFFF_FFFF, 16'hFFFF, EV_COMPLETED,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(KIND_ANNOUNCE, clock_now, 32'h0A00_0001, 16'h1234, EV_STARTED, 32'd1,
                 32'd1, 32'hFFFF_FFFF);
    send_request(KIND_ANNOUNCE, clock_now, 32'h0A00_0001, 16'h4321, EV_COMPLETED, 32'd0,
                 32'd2, 32'd5);
    send_request(KIND_ANNOUNCE, clock_now, 32'h0A00_0001, 16'h4321, EV_COMPLETED, 32'd0,
                 32'd3, 32'd7);
    send_request(KIND_ANNOUNCE, clock_now, 32'd0, 16'h0101, EV_NONE, 32'h8000_0000,
                 32'd64, 32'd1);
    // An unknown peer leaving changes nothing; a known one is removed.
    send_request(KIND_ANNOUNCE, clock_now, 32'h5555_AAAA, 16'd1, EV_STOPPED, 32'd0,
                 32'd9, 32'd0);
    send_request(KIND_ANNOUNCE, clock_now, 32'd0, 16'd1, EV_STOPPED, 32'd0, 32'd9, 32'd0);
    send_request(KIND_UNUSED, clock_now, 32'hAAAA_5555, 16'd2, EV_NONE, 32'd3, 32'd4,
                 32'd5);
    send_request(KIND_SCRAPE, clock_now, 32'd0, 16'd0, EV_NONE, 32'd0, 32'd0, 32'd0);
    // Time wraps past zero; the stored peers are then old.
    clock_now = 32'd20000;
    send_request(KIND_ANNOUNCE, clock_now, 32'h0B00_0002, 16'd80, EV_NONE, 32'd100,
                 32'd1, 32'd0);
    send_request(KIND_PURGE, clock_now, 32'd0, 16'd0, EV_NONE, 32'd0, 32'd0, 32'd0);
    send_request(KIND_SCRAPE, clock_now, 32'd0, 16'd0, EV_NONE, 32'd0, 32'd0, 32'd0);
    send_request(KIND_PURGE, 32'hFFFF_FFFF, 32'd0, 16'd0, EV_NONE, 32'd0, 32'd0, 32'd0);
    send_request(KIND_SCRAPE, clock_now, 32'd0, 16'd0, EV_NONE, 32'd0, 32'd0, 32'd0);
  endtask

  task automatic test_random(int idle, int stall, int count);
    sender_idle_pct = idle;
    stall_pct = stall;
    repeat (count) random_request();
    drain();
  endtask

  // The receiver holds off while announces keep coming, so the input backs up.
  task automatic test_backpressure();
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    repeat (8) send_request(KIND_ANNOUNCE, clock_now, ip_pool[$urandom_range(23)],
                            16'($urandom), EV_NONE, $urandom_range(1), 32'd64, $urandom);
    drain();
  endtask

  task automatic test_interval_settings();
    write_interval(16'd1);
    test_random(0, 0, 10);
    write_interval(16'hFFFF);
    test_random(0, 0, 10);
    write_interval(16'd300);
  endtask

  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_off <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !rst && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected reply: tdata %h", m_tdata);
      end else begin
        want = pending_replies.pop_front();
        if (m_tdata[12:0] !== want.seeds || m_tdata[25:13] !== want.downloaders ||
            m_tdata[57:26] !== want.completed || m_tdata[89:58] !== want.ip ||
            m_tdata[105:90] !== want.port || m_tuser !== want.has_peer ||
            m_tlast !== want.last) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: expected sc %0d dc %0d cc %0d v %0d ip %h port %h last %0d",
                     want.seeds, want.downloaders, want.completed, want.has_peer, want.ip,
                     want.port, want.last);
            $display("  got tdata %h tuser %b tlast %b", m_tdata, m_tuser, m_tlast);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tracker_peer_table_core_test NOT OK");
      $finish;
    end
  end

  initial begin
    peer_total = 0;
    seed_total = 0;
    dl_total = 0;
    cursor = 0;
    completed_total = 0;
    interval = 16'd1800;
    foreach (ip_pool[i]) ip_pool[i] = $urandom;
    ip_pool[0] = 32'd0;
    ip_pool[1] = 32'hFFFF_FFFF;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    drain();
    test_interval_settings();
    test_random(0, 0, 20);
    test_random(86, 0, 20);
    test_random(0, 86, 20);
    test_random(11, 11, 20);
    test_backpressure();
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("tracker_peer_table_core_test OK");
    end else begin
      $display("tracker_peer_table_core_test NOT OK");
    end
    $finish;
  end

endmodule
